@@ rtl/rmq_pkg.sv @@
package rmq_pkg;

   // Root pipeline: one result bit per stage
   localparam int ROOT_W = 24;
   localparam int REM_W = 47;
   localparam int TDV_W = 41;
   localparam int DV_W = 17;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CASE_TRACE = 2'd0,
      CASE_X     = 2'd1,
      CASE_Y     = 2'd2,
      CASE_Z     = 2'd3
   } case_type;

   // Classified item leaving the first front stage
   typedef struct packed {
      case_type             sel;
      logic                 bad;
      logic [16:0]          rad;
      logic [3:0]           big;
      logic [3:0][16:0]     diff;
   } class_type;

   // One component: find the largest root with root^2 * dv <= rem (initial)
   typedef struct packed {
      logic                 big;
      logic                 neg;
      logic [DV_W-1:0]      dv;
      logic [REM_W-1:0]     rem;
      logic [TDV_W-1:0]     tdv;
      logic [ROOT_W-1:0]    root;
   } lane_type;

   typedef struct packed {
      case_type             sel;
      logic                 bad;
      lane_type [3:0]       lane;
   } item_type;

   // Try one root bit: (t + 2^k)^2 dv = t^2 dv + 2^(k+1) t dv + 2^(2k) dv
   function automatic lane_type root_step(lane_type l, int k);
      logic [66:0] trial;
      lane_type    r;
      r = l;
      trial = ({26'd0, l.tdv} << (k + 1)) + ({50'd0, l.dv} << (2 * k));
      if (trial <= {20'd0, l.rem}) begin
         r.rem  = l.rem - trial[REM_W-1:0];
         r.tdv  = l.tdv + ({24'd0, l.dv} << k);
         r.root = l.root | (ROOT_W'(1) << k);
      end
      return r;
   endfunction

   // Round and saturate a finished component
   function automatic logic [15:0] lane_result(lane_type l);
      logic [ROOT_W:0]   inc;
      logic [ROOT_W-1:0] half;
      logic [15:0]       v;
      inc  = {1'b0, l.root} + (ROOT_W + 1)'(1);
      half = inc[ROOT_W:1];
      if (l.big) begin
         v = (l.rem > {{(REM_W - ROOT_W){1'b0}}, l.root}) ? l.root[15:0] + 16'd1
                                                          : l.root[15:0];
      end else if (l.neg) begin
         v = (half > ROOT_W'(32768)) ? 16'h8000 : 16'(-half[15:0]);
      end else begin
         v = (half > ROOT_W'(32767)) ? 16'h7fff : half[15:0];
      end
      return v;
   endfunction

endpackage

@@ rtl/rmq_front.sv @@
module rmq_front import rmq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m02,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   input  logic               q_full,
   output logic               q_push,
   output item_type           q_item
);

   logic                f1_vld_ff, f1_vld_in;
   class_type           f1_ff, f1_in;
   logic                f2_vld_ff, f2_vld_in;
   item_type            f2_ff, f2_in;
   logic                adv;
   logic signed [18:0]  trace, rad;
   logic signed [16:0]  d_a, d_b, d_c, s_xy, s_xz, s_yz;

   // Hold the whole front when its last stage cannot enter the queue
   assign adv       = !(f2_vld_ff && q_full);
   assign req_stall = !adv;
   assign q_push    = f2_vld_ff && adv;
   assign q_item    = f2_ff;

   // Classify: pick the case, form the radicand and the off-diagonal terms
   always_comb begin
      trace = 19'(req_m00) + 19'(req_m11) + 19'(req_m22);
      d_a  = 17'(req_m21) - 17'(req_m12);
      d_b  = 17'(req_m02) - 17'(req_m20);
      d_c  = 17'(req_m10) - 17'(req_m01);
      s_xy = 17'(req_m10) + 17'(req_m01);
      s_xz = 17'(req_m20) + 17'(req_m02);
      s_yz = 17'(req_m12) + 17'(req_m21);
      if (trace > 19'sd0) begin
         f1_in.sel = CASE_TRACE;
         rad = 19'sd16384 + trace;
      end else if (req_m00 >= req_m11 && req_m00 >= req_m22) begin
         f1_in.sel = CASE_X;
         rad = 19'sd16384 + 19'(req_m00) - 19'(req_m11) - 19'(req_m22);
      end else if (req_m11 > req_m22) begin
         f1_in.sel = CASE_Y;
         rad = 19'sd16384 + 19'(req_m11) - 19'(req_m00) - 19'(req_m22);
      end else begin
         f1_in.sel = CASE_Z;
         rad = 19'sd16384 + 19'(req_m22) - 19'(req_m00) - 19'(req_m11);
      end
      f1_in.bad = (rad <= 19'sd0);
      f1_in.rad = rad[16:0];
      unique case (f1_in.sel)
         CASE_TRACE: begin
            f1_in.big  = 4'b1000;
            f1_in.diff = {17'd0, d_c, d_b, d_a};
         end
         CASE_X: begin
            f1_in.big  = 4'b0001;
            f1_in.diff = {d_a, s_xz, s_xy, 17'd0};
         end
         CASE_Y: begin
            f1_in.big  = 4'b0010;
            f1_in.diff = {d_b, s_yz, 17'd0, s_xy};
         end
         default: begin
            f1_in.big  = 4'b0100;
            f1_in.diff = {d_c, 17'd0, s_yz, s_xz};
         end
      endcase
   end

   // Square the terms and load each component's root search
   always_comb begin
      logic [16:0] mag;
      logic [33:0] sq;
      f2_in.sel = f1_ff.sel;
      f2_in.bad = f1_ff.bad;
      for (int i = 0; i < 4; i++) begin
         mag = f1_ff.diff[i][16] ? 17'(-f1_ff.diff[i]) : f1_ff.diff[i];
         sq  = {17'd0, mag} * {17'd0, mag};
         f2_in.lane[i].big  = f1_ff.big[i];
         f2_in.lane[i].neg  = f1_ff.diff[i][16];
         f2_in.lane[i].tdv  = '0;
         f2_in.lane[i].root = '0;
         if (f1_ff.bad) begin
            f2_in.lane[i].dv  = DV_W'(1);
            f2_in.lane[i].rem = '0;
         end else if (f1_ff.big[i]) begin
            f2_in.lane[i].dv  = DV_W'(1);
            f2_in.lane[i].rem = {18'd0, f1_ff.rad, 12'd0};
         end else begin
            f2_in.lane[i].dv  = f1_ff.rad;
            f2_in.lane[i].rem = {sq[32:0], 14'd0};
         end
      end
   end

   assign f1_vld_in = req_valid;
   assign f2_vld_in = f1_vld_ff;

   // Advance the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= f1_vld_in;
         f2_vld_ff <= f2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
      end
   end

endmodule

@@ rtl/rmq_fifo.sv @@
module rmq_fifo import rmq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head
);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/rmq_back.sv @@
module rmq_back import rmq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  item_type    q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_qx,
   output logic [15:0] rsp_qy,
   output logic [15:0] rsp_qz,
   output logic [15:0] rsp_qw,
   output logic [1:0]  rsp_case_taken,
   output logic        rsp_invalid
);

   item_type            stage_ff [ROOT_W];
   item_type            stage_in [ROOT_W];
   logic [ROOT_W-1:0]   stage_vld_ff, stage_vld_in;
   logic                out_vld_ff, out_vld_in;
   logic [3:0][15:0]    q_ff, q_in;
   case_type            sel_ff;
   logic                bad_ff;
   logic                adv;
   item_type            last;

   // Hold the whole back pipe while a finished result waits
   assign adv   = !(out_vld_ff && rsp_stall);
   assign q_pop = adv && !q_empty;

   // One root bit per stage, most significant first
   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      item_type src;
      if (j == 0) begin : g_head
         assign src = q_head;
      end else begin : g_prev
         assign src = stage_ff[j-1];
      end
      always_comb begin
         stage_in[j] = src;
         for (int i = 0; i < 4; i++) begin
            stage_in[j].lane[i] = root_step(src.lane[i], ROOT_W - 1 - j);
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            stage_ff[j] <= stage_in[j];
         end
      end
   end

   assign stage_vld_in = {stage_vld_ff[ROOT_W-2:0], q_pop};
   assign out_vld_in   = stage_vld_ff[ROOT_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
         out_vld_ff   <= 1'b0;
      end else if (adv) begin
         stage_vld_ff <= stage_vld_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // Round, saturate and zero the components of a bad radicand
   assign last = stage_ff[ROOT_W-1];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_in[i] = last.bad ? 16'd0 : lane_result(last.lane[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff   <= q_in;
         sel_ff <= last.sel;
         bad_ff <= last.bad;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_qx         = q_ff[0];
   assign rsp_qy         = q_ff[1];
   assign rsp_qz         = q_ff[2];
   assign rsp_qw         = q_ff[3];
   assign rsp_case_taken = sel_ff;
   assign rsp_invalid    = bad_ff;

endmodule

@@ rtl/rotation_matrix_to_quaternion.sv @@
// Converts a 3x3 rotation matrix (signed Q2.14 entries) to a quaternion
// (x, y, z, w, signed Q2.14) by Shepperd's case split, exact to the last bit:
// the largest component is round(0.5*sqrt(radicand)) and the others are
// round(D*0.5/sqrt(radicand)), ties away from zero, saturated. A radicand of
// zero or below sets rsp_invalid and gives zero components; rsp_case_taken
// always reports the branch chosen. One item is accepted per cycle unless
// req_stall is high and one result leaves per cycle unless rsp_stall is
// high. Items pass two front stages (classify, square), the four-entry
// queue, 24 bit-per-stage root and divide stages and the output register.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m02,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_qx,
   output logic signed [15:0] rsp_qy,
   output logic signed [15:0] rsp_qz,
   output logic signed [15:0] rsp_qw,
   output logic [1:0]         rsp_case_taken,
   output logic               rsp_invalid
);

   logic     q_full, q_push, q_pop, q_empty;
   item_type q_item, q_head;

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_m00   (req_m00),
      .req_m01   (req_m01),
      .req_m02   (req_m02),
      .req_m10   (req_m10),
      .req_m11   (req_m11),
      .req_m12   (req_m12),
      .req_m20   (req_m20),
      .req_m21   (req_m21),
      .req_m22   (req_m22),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   rmq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   rmq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_qx         (rsp_qx),
      .rsp_qy         (rsp_qy),
      .rsp_qz         (rsp_qz),
      .rsp_qw         (rsp_qw),
      .rsp_case_taken (rsp_case_taken),
      .rsp_invalid    (rsp_invalid)
   );

   // A bad radicand gives all-zero components
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |->
         rsp_qx == 16'd0 && rsp_qy == 16'd0 && rsp_qz == 16'd0 && rsp_qw == 16'd0)
      else $error("invalid result with nonzero component");

   // The component from the square root is positive in every result not flagged invalid
   a_big_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invalid |->
         (rsp_case_taken == CASE_TRACE && rsp_qw > 16'sd0) ||
         (rsp_case_taken == CASE_X && rsp_qx > 16'sd0) ||
         (rsp_case_taken == CASE_Y && rsp_qy > 16'sd0) ||
         (rsp_case_taken == CASE_Z && rsp_qz > 16'sd0))
      else $error("root component not positive");

   // Never push into a full queue or pop an empty one
   a_queue_bounds: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full) && !(q_pop && q_empty))
      else $error("queue overflow or underflow");

endmodule

@@ verif/rotation_matrix_to_quaternion_test.sv @@
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_test;
   import rmq_pkg::*;

   typedef struct {
      logic signed [15:0] m [9];
   } matrix_type;

   typedef struct {
      logic signed [15:0] qx, qy, qz, qw;
      case_type           sel;
      logic               invalid;
   } quat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_m [9];
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw;
   logic [1:0]         rsp_case_taken;
   logic               rsp_invalid;

   matrix_type pending_matrices[$];
   quat_type   expected_quats[$];
   int         errors = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   bit         hold_send = 1'b0;
   bit         req_taken = 1'b0;

   rotation_matrix_to_quaternion dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_qx(rsp_qx), .rsp_qy(rsp_qy), .rsp_qz(rsp_qz), .rsp_qw(rsp_qw),
      .rsp_case_taken(rsp_case_taken), .rsp_invalid(rsp_invalid)
   );

   initial foreach (req_m[i]) req_m[i] = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // round(sqrt(rad * 4096))
   function automatic logic signed [15:0] major_part(longint rad);
      longint unsigned x, s;
      x = longint'(rad) << 12;
      s = int_sqrt(x);
      if (x - s * s > s) s++;
      return 16'(s);
   endfunction

   // round(64 * d / sqrt(rad)), ties away from zero, saturated
   function automatic logic signed [15:0] minor_part(longint d, longint rad);
      longint unsigned mag, n;
      mag = d < 0 ? -d : d;
      n = (int_sqrt((mag * mag * 16384) / rad) + 1) >> 1;
      if (d < 0) begin
         if (n > 32768) n = 32768;
         return 16'(-longint'(n));
      end
      if (n > 32767) n = 32767;
      return 16'(n);
   endfunction

   function automatic quat_type matrix_to_quat(matrix_type mt);
      longint   a [9];
      longint   tr, rad;
      quat_type q;
      foreach (a[i]) a[i] = mt.m[i];
      tr = a[0] + a[4] + a[8];
      if (tr > 0) begin
         q.sel = CASE_TRACE; rad = 16384 + tr;
      end else if (a[0] >= a[4] && a[0] >= a[8]) begin
         q.sel = CASE_X; rad = 16384 + a[0] - a[4] - a[8];
      end else if (a[4] > a[8]) begin
         q.sel = CASE_Y; rad = 16384 + a[4] - a[0] - a[8];
      end else begin
         q.sel = CASE_Z; rad = 16384 + a[8] - a[0] - a[4];
      end
      q.invalid = rad <= 0;
      {q.qx, q.qy, q.qz, q.qw} = '0;
      if (!q.invalid) begin
         case (q.sel)
            CASE_TRACE: begin
               q.qw = major_part(rad);
               q.qx = minor_part(a[7] - a[5], rad);
               q.qy = minor_part(a[2] - a[6], rad);
               q.qz = minor_part(a[3] - a[1], rad);
            end
            CASE_X: begin
               q.qx = major_part(rad);
               q.qy = minor_part(a[3] + a[1], rad);
               q.qz = minor_part(a[6] + a[2], rad);
               q.qw = minor_part(a[7] - a[5], rad);
            end
            CASE_Y: begin
               q.qx = minor_part(a[1] + a[3], rad);
               q.qy = major_part(rad);
               q.qz = minor_part(a[5] + a[7], rad);
               q.qw = minor_part(a[2] - a[6], rad);
            end
            default: begin
               q.qx = minor_part(a[2] + a[6], rad);
               q.qy = minor_part(a[5] + a[7], rad);
               q.qz = major_part(rad);
               q.qw = minor_part(a[3] - a[1], rad);
            end
         endcase
      end
      return q;
   endfunction

   function automatic matrix_type mt_from_port();
      matrix_type mt;
      foreach (mt.m[i]) mt.m[i] = req_m[i];
      return mt;
   endfunction

   // Record each request transfer at the edge that accepts it
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_quats.push_back(matrix_to_quat(mt_from_port()));
         void'(pending_matrices.pop_front());
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   // Drive request transfers at the falling edge; hold payload until taken
   always @(negedge clock) begin
      matrix_type mt;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_matrices.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
               mt = pending_matrices[0];
               foreach (req_m[i]) req_m[i] <= mt.m[i];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
      end
   end

   // Check each response transfer against the oldest prediction
   always @(posedge clock) begin
      quat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quats.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            e = expected_quats.pop_front();
            if (rsp_qx !== e.qx) begin
               $error("qx expected %0d actual %0d", e.qx, rsp_qx); errors++;
            end
            if (rsp_qy !== e.qy) begin
               $error("qy expected %0d actual %0d", e.qy, rsp_qy); errors++;
            end
            if (rsp_qz !== e.qz) begin
               $error("qz expected %0d actual %0d", e.qz, rsp_qz); errors++;
            end
            if (rsp_qw !== e.qw) begin
               $error("qw expected %0d actual %0d", e.qw, rsp_qw); errors++;
            end
            if (rsp_case_taken !== e.sel) begin
               $error("case_taken expected %0d actual %0d", e.sel, rsp_case_taken);
               errors++;
            end
            if (rsp_invalid !== e.invalid) begin
               $error("invalid expected %0d actual %0d", e.invalid, rsp_invalid);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [15:0] rand_entry();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(32768) - 16384);
         3: return 16'($urandom_range(1024) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // Rotation-like matrix: dominant diagonal sign pattern picks the case
   function automatic matrix_type rand_rotation();
      matrix_type mt;
      int         dom;
      dom = $urandom_range(3);
      foreach (mt.m[i]) mt.m[i] = 16'($urandom_range(16384) - 8192);
      mt.m[0] = 16'($urandom_range(16384) - 8192);
      if (dom == 0) begin
         mt.m[0] = 16'($urandom_range(16384)); mt.m[4] = 16'($urandom_range(16384));
         mt.m[8] = 16'($urandom_range(16384));
      end else begin
         mt.m[0] = (dom == 1) ? 16'($urandom_range(16384)) : -16'sd8000;
         mt.m[4] = (dom == 2) ? 16'($urandom_range(16384)) : -16'sd8000;
         mt.m[8] = (dom == 3) ? 16'($urandom_range(16384)) : -16'sd8000;
         mt.m[4 * (dom - 1)] = 16'($urandom_range(16384) - 8192);
      end
      return mt;
   endfunction

   task automatic add_matrix(input int d0, d1, d2, o);
      matrix_type mt;
      foreach (mt.m[i]) mt.m[i] = 16'(o);
      mt.m[0] = 16'(d0); mt.m[4] = 16'(d1); mt.m[8] = 16'(d2);
      pending_matrices.push_back(mt);
   endtask

   task automatic wait_drained();
      while (pending_matrices.size() > 0 || req_valid || expected_quats.size() > 0)
         @(posedge clock);
   endtask

   task automatic add_random(input int count);
      matrix_type mt;
      repeat (count) begin
         if ($urandom_range(9) < 7) mt = rand_rotation();
         else foreach (mt.m[i]) mt.m[i] = rand_entry();
         pending_matrices.push_back(mt);
      end
   endtask

   initial begin
      matrix_type mt;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // Directed: identity, each case, ties, extremes, bad radicand, saturation
      add_matrix(16384, 16384, 16384, 0);
      add_matrix(16384, -16384, -16384, 0);
      add_matrix(-16384, 16384, -16384, 0);
      add_matrix(-16384, -16384, 16384, 0);
      add_matrix(-100, -100, -100, 0);
      add_matrix(-100, -200, -100, 0);
      add_matrix(-300, -200, -200, 0);
      add_matrix(0, 0, 0, 0);
      add_matrix(-32768, -32768, -32768, 16'sh7fff);
      add_matrix(-32768, 32767, 32767, 16'sh8000);
      add_matrix(32767, 32767, 32767, 16'sh8000);
      add_matrix(32767, -32768, -32768, 16'sh7fff);
      add_matrix(-32768, 0, -32768, 16'sh7fff);
      add_matrix(-32768, -32768, 0, 16'sh8000);
      add_matrix(1, -1, -1, 16'sh7fff);
      add_matrix(-16384, -16384, -16384, 0);
      add_matrix(-16383, -16384, -16384, 16'sh8000);
      for (int b = 0; b < 16; b++) begin
         foreach (mt.m[i]) mt.m[i] = 16'sd1 << b;
         pending_matrices.push_back(mt);
         foreach (mt.m[i]) mt.m[i] = ~(16'sd1 << b);
         pending_matrices.push_back(mt);
      end
      // Hold off the sender, then release it and wait until everything is back
      hold_send = 1'b1;
      repeat (5) @(posedge clock);
      hold_send = 1'b0;
      wait_drained();
      send_idle_pct = 22; recv_idle_pct = 74;
      add_random(330);
      wait_drained();
      send_idle_pct = 74; recv_idle_pct = 22;
      add_random(330);
      wait_drained();
      send_idle_pct = 0; recv_idle_pct = 0;
      add_random(340);
      wait_drained();
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_quats.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_fifo.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion.sv
verif/rotation_matrix_to_quaternion_test.sv
